[hdl/paged_bump_allocator_assert.svh]
// assertion macros used by the paged bump allocator module
`ifndef PAGED_BUMP_ALLOCATOR_ASSERT_SVH
`define PAGED_BUMP_ALLOCATOR_ASSERT_SVH

// checked only while out of reset
`define PBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/pba_pkg.sv]
// constants and types of the paged bump allocator
package pba_pkg;

  localparam int PAGE_BYTES  = 4096;
  localparam int MAX_PAGES   = 16;
  localparam int ALIGNMENT   = 8;
  localparam int MISS_LIMIT  = 4;
  localparam int POOL_HEADER = 32;
  localparam int PAGE_HEADER = 40;

  localparam int PAYLOAD_MAX = PAGE_BYTES - PAGE_HEADER;

  localparam int SIZE_W = 16;
  localparam int STAT_W = 2;
  localparam int PIDX_W = 4;
  localparam int OFF_W  = 12;

  localparam int FILL_W = $clog2(PAGE_BYTES + 1);
  localparam int RND_W  = FILL_W + 1;
  localparam int SUM_W  = RND_W + 1 > SIZE_W + 1 ? RND_W + 1 : SIZE_W + 1;
  localparam int PG_W   = MAX_PAGES > 1 ? $clog2(MAX_PAGES) : 1;
  localparam int CNT_W  = $clog2(MAX_PAGES + 1);
  localparam int MISS_W = 3;

  localparam logic [CNT_W-1:0]  MAX_PAGES_C  = CNT_W'(MAX_PAGES);
  localparam logic [MISS_W-1:0] MISS_LIMIT_C = MISS_W'(MISS_LIMIT);
  localparam logic [FILL_W-1:0] FIRST_FILL   = FILL_W'(POOL_HEADER + PAGE_HEADER);
  localparam logic [FILL_W-1:0] PAGE_HDR_C   = FILL_W'(PAGE_HEADER);

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERSIZE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd2;

  typedef struct packed {
    logic                fill_we;
    logic                miss_we;
    logic [PG_W-1:0]     addr;
    logic [FILL_W-1:0]   fill;
    logic [MISS_W-1:0]   miss;
  } store_wr_t;

endpackage

[hdl/pba_fit_unit.sv]
// shared align-and-fit unit: rounds a fill offset up and checks the block fits
module pba_fit_unit (
  input  logic [pba_pkg::FILL_W-1:0] fill,
  input  logic [pba_pkg::SIZE_W-1:0] size,
  output logic [pba_pkg::RND_W-1:0]  pos,
  output logic                       fits,
  output logic [pba_pkg::FILL_W-1:0] new_fill
);
  import pba_pkg::*;

  logic [RND_W-1:0] bumped;
  logic [SUM_W-1:0] end_pos;

  assign bumped   = RND_W'(fill) + RND_W'(ALIGNMENT - 1);
  assign pos      = RND_W'((bumped / ALIGNMENT) * ALIGNMENT);
  assign end_pos  = SUM_W'(pos) + SUM_W'(size);
  assign fits     = (SUM_W'(pos) <= SUM_W'(PAGE_BYTES)) && (end_pos <= SUM_W'(PAGE_BYTES));
  assign new_fill = FILL_W'(end_pos);

endmodule

[hdl/pba_page_store.sv]
// per-page fill offsets and miss counters, one read and one write port
module pba_page_store (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clr,
  input  pba_pkg::store_wr_t         wr,
  input  logic [pba_pkg::PG_W-1:0]   rd_addr,
  output logic [pba_pkg::FILL_W-1:0] rd_fill,
  output logic [pba_pkg::MISS_W-1:0] rd_miss
);
  import pba_pkg::*;

  logic [FILL_W-1:0] fill_r [MAX_PAGES];
  logic [MISS_W-1:0] miss_r [MAX_PAGES];

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      for (int i = 0; i < MAX_PAGES; i++) begin
        fill_r[i] <= (i == 0) ? FIRST_FILL : '0;
        miss_r[i] <= '0;
      end
    end else begin
      if (wr.fill_we) begin
        fill_r[wr.addr] <= wr.fill;
      end
      if (wr.miss_we) begin
        miss_r[wr.addr] <= wr.miss;
      end
    end
  end

  assign rd_fill = fill_r[rd_addr];
  assign rd_miss = miss_r[rd_addr];

endmodule

[hdl/paged_bump_allocator.sv]
// Paged bump allocator: an allocate item walks the open pages from the current
// page onward, one page per cycle through a single align-and-fit unit, and
// places the block in the first page that holds it; if none does, the walk
// then opens a new page (or reports no space once all 16 pages are open).
// An allocation's result is registered and valid once its walk ends; release
// and oversize items give their result the cycle after acceptance. The block
// takes one item at a time: in_ready is high only when no item is in work and
// the previous result has been taken.
module paged_bump_allocator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_mode,
  input  logic [pba_pkg::SIZE_W-1:0] in_req_size,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pba_pkg::STAT_W-1:0] out_status,
  output logic [pba_pkg::PIDX_W-1:0] out_page_index,
  output logic [pba_pkg::OFF_W-1:0]  out_offset
);
  import pba_pkg::*;

`include "paged_bump_allocator_assert.svh"

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cur_page_r, cur_page_nxt;
  logic [CNT_W-1:0]  pages_open_r, pages_open_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [PIDX_W-1:0] page_r, page_nxt;
  logic [OFF_W-1:0]  offset_r, offset_nxt;

  store_wr_t         wr;
  logic              store_clr;
  logic [FILL_W-1:0] rd_fill;
  logic [MISS_W-1:0] rd_miss;
  logic [MISS_W-1:0] miss_inc;
  logic              in_range;
  logic              accept;

  logic [FILL_W-1:0] fit_fill;
  logic [RND_W-1:0]  fit_pos;
  logic              fit_ok;
  logic [FILL_W-1:0] fit_new;

  assign accept   = in_valid && in_ready;
  assign in_range = idx_r < pages_open_r;
  assign fit_fill = in_range ? rd_fill : PAGE_HDR_C;
  assign miss_inc = (rd_miss < MISS_LIMIT_C) ? rd_miss + 1'b1 : rd_miss;

  pba_page_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (store_clr),
    .wr      (wr),
    .rd_addr (PG_W'(idx_r)),
    .rd_fill (rd_fill),
    .rd_miss (rd_miss)
  );

  pba_fit_unit u_fit (
    .fill     (fit_fill),
    .size     (size_r),
    .pos      (fit_pos),
    .fits     (fit_ok),
    .new_fill (fit_new)
  );

  always_comb begin
    state_nxt      = state_r;
    cur_page_nxt   = cur_page_r;
    pages_open_nxt = pages_open_r;
    idx_nxt        = idx_r;
    size_nxt       = size_r;
    status_nxt     = status_r;
    page_nxt       = page_r;
    offset_nxt     = offset_r;
    store_clr      = 1'b0;
    wr             = '0;
    wr.addr        = PG_W'(idx_r);
    wr.fill        = fit_new;
    wr.miss        = miss_inc;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          size_nxt = in_req_size;
          idx_nxt  = cur_page_r;
          page_nxt   = '0;
          offset_nxt = '0;
          if (in_mode == MODE_RELEASE) begin
            store_clr      = 1'b1;
            cur_page_nxt   = '0;
            pages_open_nxt = CNT_W'(1);
            status_nxt     = STAT_OK;
            state_nxt      = ST_OUT;
          end else if ({1'b0, in_req_size} > (SIZE_W + 1)'(PAYLOAD_MAX)) begin
            status_nxt = STAT_OVERSIZE;
            state_nxt  = ST_OUT;
          end else begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (in_range) begin
          if (fit_ok) begin
            wr.fill_we = 1'b1;
            status_nxt = STAT_OK;
            page_nxt   = PIDX_W'(idx_r);
            offset_nxt = OFF_W'(fit_pos);
            state_nxt  = ST_OUT;
          end else begin
            wr.miss_we = 1'b1;
            if (miss_inc >= MISS_LIMIT_C) begin
              cur_page_nxt = idx_r + 1'b1;
            end
            idx_nxt = idx_r + 1'b1;
          end
        end else if (pages_open_r >= MAX_PAGES_C) begin
          status_nxt = STAT_NO_SPACE;
          state_nxt  = ST_OUT;
        end else begin
          // open a fresh page, it holds any size that passed the payload check
          wr.addr        = PG_W'(pages_open_r);
          wr.fill_we     = 1'b1;
          wr.miss_we     = 1'b1;
          wr.miss        = '0;
          pages_open_nxt = pages_open_r + 1'b1;
          status_nxt     = STAT_OK;
          page_nxt       = PIDX_W'(pages_open_r);
          offset_nxt     = OFF_W'(fit_pos);
          state_nxt      = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cur_page_r   <= '0;
      pages_open_r <= CNT_W'(1);
      idx_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      cur_page_r   <= cur_page_nxt;
      pages_open_r <= pages_open_nxt;
      idx_r        <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r   <= size_nxt;
    status_r <= status_nxt;
    page_r   <= page_nxt;
    offset_r <= offset_nxt;
  end

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = (state_r == ST_OUT);
  assign out_status     = status_r;
  assign out_page_index = page_r;
  assign out_offset     = offset_r;

  `PBA_ASSERT(a_open_range, (pages_open_r != '0) && (pages_open_r <= MAX_PAGES_C), "bad open count")
  `PBA_ASSERT(a_cur_page_bound, cur_page_r <= pages_open_r, "current page past open pages")
  `PBA_ASSERT_ALWAYS(a_one_side_only, !rst_n || !(in_ready && out_valid), "ready while busy")
  `PBA_ASSERT(a_walk_idx, (state_r == ST_WALK) && in_range |-> idx_r < MAX_PAGES_C, "walk past end")

endmodule

[sim/paged_bump_allocator_tb.sv]
// testbench for the paged bump allocator: directed and random requests checked by a scoreboard
module paged_bump_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pba_pkg::*;

  localparam int CLK_PERIOD  = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 40;
  localparam int PHASE_ITEMS = 170;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [PIDX_W-1:0] page_index;
    logic [OFF_W-1:0]  offset;
  } alloc_result_t;

  // mirror of the pool: fill level and miss tally per page, current and open page counts
  class alloc_scoreboard;
    logic [FILL_W-1:0] fill_level [MAX_PAGES];
    logic [MISS_W-1:0] miss_tally [MAX_PAGES];
    int unsigned       cur_page;
    int unsigned       open_pages;
    alloc_result_t     expected_q [$];
    int unsigned       mismatches;

    function new();
      empty_pool();
      mismatches = 0;
    endfunction

    function void empty_pool();
      for (int p = 0; p < MAX_PAGES; p++) begin
        fill_level[p] = '0;
        miss_tally[p] = '0;
      end
      fill_level[0] = FILL_W'(POOL_HEADER + PAGE_HEADER);
      cur_page = 0;
      open_pages = 1;
    endfunction

    function int unsigned align_up(int unsigned v);
      return ((v + ALIGNMENT - 1) / ALIGNMENT) * ALIGNMENT;
    endfunction

    function void note_input(logic mode, logic [SIZE_W-1:0] req_size);
      alloc_result_t res;
      int unsigned   req;
      int unsigned   pos;
      int unsigned   pg;
      bit            placed;
      req = req_size;
      placed = 1'b0;
      res = '{STAT_OK, '0, '0};
      if (mode == MODE_RELEASE) begin
        empty_pool();
      end else if (req > PAYLOAD_MAX) begin
        res.status = STAT_OVERSIZE;
      end else begin
        // walk open pages from the current one; the walk start is fixed on entry
        for (pg = cur_page; pg < open_pages && pg < MAX_PAGES && !placed; pg++) begin
          pos = align_up(fill_level[pg]);
          if (pos <= PAGE_BYTES && PAGE_BYTES - pos >= req) begin
            fill_level[pg] = FILL_W'(pos + req);
            res = '{STAT_OK, PIDX_W'(pg), OFF_W'(pos)};
            placed = 1'b1;
          end else begin
            if (miss_tally[pg] < MISS_LIMIT) miss_tally[pg] = miss_tally[pg] + 1'b1;
            if (miss_tally[pg] >= MISS_LIMIT) cur_page = pg + 1;
          end
        end
        if (!placed) begin
          if (open_pages >= MAX_PAGES) begin
            res.status = STAT_NO_SPACE;
          end else begin
            pg = open_pages;
            open_pages++;
            miss_tally[pg] = '0;
            pos = align_up(PAGE_HEADER);
            fill_level[pg] = FILL_W'(pos + req);
            res = '{STAT_OK, PIDX_W'(pg), OFF_W'(pos)};
          end
        end
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [STAT_W-1:0] status, logic [PIDX_W-1:0] page_index,
                               logic [OFF_W-1:0] offset);
      alloc_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d page_index %0d offset %0d",
               status, page_index, offset);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatches++;
        end
        if (page_index !== want.page_index) begin
          $error("page_index: expected %0d, got %0d", want.page_index, page_index);
          mismatches++;
        end
        if (offset !== want.offset) begin
          $error("offset: expected %0d, got %0d", want.offset, offset);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_mode;
  logic [SIZE_W-1:0] in_req_size;
  logic              out_valid;
  logic              out_ready;
  logic [STAT_W-1:0] out_status;
  logic [PIDX_W-1:0] out_page_index;
  logic [OFF_W-1:0]  out_offset;

  alloc_scoreboard board = new();
  int unsigned     send_idle_pct = 0;
  int unsigned     stall_pct = 0;
  bit              hold_off = 1'b0;
  int unsigned     cycle_count = 0;

  paged_bump_allocator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_req_size    (in_req_size),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_page_index (out_page_index),
    .out_offset     (out_offset)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_result(out_status, out_page_index, out_offset);
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic mode, input logic [SIZE_W-1:0] req_size);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_req_size <= req_size;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_input(mode, req_size);
    @(negedge clk);
  endtask

  function automatic logic [SIZE_W-1:0] random_size();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) return SIZE_W'($urandom_range(64));
    if (pick < 70) return SIZE_W'($urandom_range(1023, 65));
    if (pick < 90) return SIZE_W'($urandom_range(PAYLOAD_MAX, 1024));
    if (pick < 95) return SIZE_W'($urandom_range(PAYLOAD_MAX, PAYLOAD_MAX - 160));
    return SIZE_W'($urandom_range(65535, PAYLOAD_MAX + 1));
  endfunction

  // allocation runs with random content, now and then a release to restart the pool
  task automatic send_random(input int unsigned count);
    int unsigned n;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(63) == 0) send_item(MODE_RELEASE, SIZE_W'($urandom));
      else send_item(MODE_ALLOC, random_size());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_ALLOC;
    in_req_size = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero size, misaligned fill, both sides of the payload limit
    send_item(MODE_ALLOC, 16'd0);
    send_item(MODE_ALLOC, 16'd3);
    send_item(MODE_ALLOC, 16'd1);
    send_item(MODE_ALLOC, SIZE_W'(PAYLOAD_MAX + 1));
    send_item(MODE_ALLOC, 16'hFFFF);
    send_item(MODE_RELEASE, 16'hFFFF);
    // fill page 0 to the last byte, then a zero-size block lands at the page end
    send_item(MODE_ALLOC, SIZE_W'(PAGE_BYTES - POOL_HEADER - PAGE_HEADER));
    send_item(MODE_ALLOC, 16'd0);
    // full pages: misses pile up to the limit until no page is left
    repeat (MAX_PAGES) send_item(MODE_ALLOC, SIZE_W'(PAYLOAD_MAX));
    send_item(MODE_RELEASE, 16'd0);

    send_idle_pct = 0;
    stall_pct = 0;
    send_random(PHASE_ITEMS / 2);
    hold_off = 1'b1;
    send_random(8);
    send_random(PHASE_ITEMS / 2);

    send_idle_pct = 58;
    stall_pct = 0;
    send_random(PHASE_ITEMS);

    send_idle_pct = 0;
    stall_pct = 58;
    send_random(PHASE_ITEMS);

    send_idle_pct = 35;
    stall_pct = 35;
    send_random(PHASE_ITEMS);

    in_valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/pba_pkg.sv
hdl/pba_fit_unit.sv
hdl/pba_page_store.sv
hdl/paged_bump_allocator.sv
sim/paged_bump_allocator_tb.sv
